/* hw/rtl/swm_pkg.sv */
// Shared constants and types of the sliding window median filter.
`timescale 1ns / 1ps

package swm_pkg;

   // Default sizes handed to the top level
   localparam int WINDOW_MAX_DEF  = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   // Window length register
   localparam int CFG_W     = 6;
   localparam int CFG_RESET = 3;

   // Broadcast control seen by every cell of the sorted chain
   typedef struct packed {
      logic shift;      // a request is taken this cycle
      logic full;       // the window is full, the oldest sample leaves
      logic left_mode;  // leaving sample sorts at or before the new one
   } swm_ctl_type;

   // Flags one cell shows to its neighbors
   typedef struct packed {
      logic le;         // holds a sample, and it is <= the new sample
      logic eqo;        // holds a sample equal to the leaving one
      logic before_rm;  // lies before the cell being removed
   } swm_nbr_type;

endpackage

/* hw/rtl/swm_cell.sv */
// One cell of the sorted chain: holds one sample and moves it left or right.
`timescale 1ns / 1ps

module swm_cell #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  swm_pkg::swm_ctl_type           ctl,
   input  logic signed [SAMPLE_BITS-1:0]  sample,
   input  logic signed [SAMPLE_BITS-1:0]  old_sample,
   input  logic                           occ,
   input  logic signed [SAMPLE_BITS-1:0]  left_value,
   input  swm_pkg::swm_nbr_type           left_flags,
   input  logic signed [SAMPLE_BITS-1:0]  right_value,
   input  swm_pkg::swm_nbr_type           right_flags,
   output logic signed [SAMPLE_BITS-1:0]  value,
   output swm_pkg::swm_nbr_type           flags
);
   import swm_pkg::*;

   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic signed [SAMPLE_BITS-1:0] value_in;
   logic                          after_rm;
   logic                          is_rm;

   // Position of this cell relative to the insert and remove points
   always_comb begin
      flags.le  = occ && (value_ff <= sample);
      flags.eqo = occ && (value_ff == old_sample);
      // first cell equal to the leaving sample is the one removed
      after_rm  = ctl.full && occ && ((value_ff > old_sample) || left_flags.eqo);
      is_rm     = ctl.full && flags.eqo && !left_flags.eqo;
      flags.before_rm = occ && !after_rm && !is_rm;
   end

   // Next content: keep, take a neighbor, or take the new sample
   always_comb begin
      value_in = value_ff;
      if (ctl.left_mode) begin
         // gap opens at the removed cell, closes at the insert point
         if (!flags.before_rm && right_flags.le) begin
            value_in = right_value;
         end else if (!flags.before_rm && flags.le) begin
            value_in = sample;
         end
      end else begin
         // gap opens at the insert point, closes at the removed cell
         if (!flags.le && left_flags.le) begin
            value_in = sample;
         end else if (!flags.le && left_flags.before_rm) begin
            value_in = left_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

/* hw/rtl/swm_ring.sv */
// Arrival-order sample ring with a registered read of the next leaving sample.
`timescale 1ns / 1ps

module swm_ring #(
   parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
   localparam int POS_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [POS_W-1:0]              wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic [POS_W-1:0]              rd_addr,
   output logic signed [SAMPLE_BITS-1:0] rd_data
);
   import swm_pkg::*;

   logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; a one-sample window reads back what is written now
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sliding_window_median_top.sv */
// Top level of the sliding window median filter.
`timescale 1ns / 1ps

// Running median over the last window_length signed samples (1 to WINDOW_MAX,
// 0 reads as 1, larger values saturate). Unless held off, the block takes one
// request per cycle: the samples sit in a sorted chain of cells that drops the
// leaving sample and inserts the new one in a single shift, and a ring memory
// prefetches the leaving sample for the next request. Once the window is full
// each request yields one response, twice the median (sum of the two middle
// samples for an even window), through the pending flag and output register.
// While the window fills no response comes. A request is held off only while
// a response waits in the output register and another is ready behind it.
// A write of csr_data restarts filling; no clearing pass follows reset.
module sliding_window_median_top #(
   parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
   localparam int REQ_W      = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W      = ((SAMPLE_BITS + 8) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_W-1:0]          req_tdata,   // [SAMPLE_BITS-1:0] sample
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,   // [SAMPLE_BITS:0] median_doubled
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [swm_pkg::CFG_W-1:0] csr_data     // window_length
);
   import swm_pkg::*;

   localparam int POS_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
   localparam int K_RESET = (CFG_RESET > WINDOW_MAX) ? WINDOW_MAX : CFG_RESET;

   // Handshakes
   logic accept;
   logic cfg_wr;
   logic out_load;

   // Window control
   logic [CNT_W-1:0] k_ff, k_cfg;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0] rp_ff, rp_in, next_pos;
   logic [CNT_W-1:0] pos_inc;
   logic             full;
   logic             pend_ff, pend_in;

   // Median tap selects
   logic [WINDOW_MAX-1:0] mask_a_ff, mask_b_ff;
   logic [WINDOW_MAX-1:0] mask_a_cfg, mask_b_cfg;
   logic [WINDOW_MAX-1:0] mask_a_rst, mask_b_rst;

   // Datapath
   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [SAMPLE_BITS-1:0] old_sample;
   swm_ctl_type                   ctl;
   logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
   swm_nbr_type                   cell_flags [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] tap_a, tap_b;
   logic signed [SAMPLE_BITS:0]   median;
   logic [SAMPLE_BITS:0]          rsp_data_ff;
   logic                          rsp_valid_ff;

   assign sample   = req_tdata[SAMPLE_BITS-1:0];
   assign cfg_wr   = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign out_load = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || out_load;
   assign accept   = req_tvalid && req_tready;
   assign full     = (fill_ff >= k_ff);

   // Window length after clamping, and the two middle taps it selects
   always_comb begin
      int kc, ka, kr, ra;
      if (csr_data == '0) begin
         kc = 1;
      end else if (int'(csr_data) > WINDOW_MAX) begin
         kc = WINDOW_MAX;
      end else begin
         kc = int'(csr_data);
      end
      k_cfg = CNT_W'(kc);
      ka = ((kc % 2) == 1) ? (kc / 2) : (kc / 2 - 1);
      kr = K_RESET;
      ra = ((kr % 2) == 1) ? (kr / 2) : (kr / 2 - 1);
      for (int i = 0; i < WINDOW_MAX; i++) begin
         mask_a_cfg[i] = (i == ka);
         mask_b_cfg[i] = (i == kc / 2);
         mask_a_rst[i] = (i == ra);
         mask_b_rst[i] = (i == kr / 2);
      end
   end

   // Ring position and fill count
   always_comb begin
      pos_inc  = CNT_W'(rp_ff) + 1'b1;
      next_pos = (pos_inc >= k_ff) ? '0 : POS_W'(pos_inc);
      rp_in    = rp_ff;
      fill_in  = fill_ff;
      pend_in  = pend_ff;
      if (out_load) begin
         pend_in = 1'b0;
      end
      if (cfg_wr) begin
         rp_in   = '0;
         fill_in = '0;
      end else if (accept) begin
         rp_in   = next_pos;
         fill_in = full ? fill_ff : fill_ff + 1'b1;
         pend_in = full || ((fill_ff + 1'b1) == k_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff      <= CNT_W'(K_RESET);
         mask_a_ff <= mask_a_rst;
         mask_b_ff <= mask_b_rst;
         rp_ff     <= '0;
         fill_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         if (cfg_wr) begin
            k_ff      <= k_cfg;
            mask_a_ff <= mask_a_cfg;
            mask_b_ff <= mask_b_cfg;
         end
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
         pend_ff <= pend_in;
      end
   end

   // Arrival ring, read ahead at the next request's position
   swm_ring #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (rp_ff),
      .wr_data (sample),
      .rd_addr (rp_in),
      .rd_data (old_sample)
   );

   // Sorted cell chain
   always_comb begin
      ctl.shift     = accept;
      ctl.full      = full;
      ctl.left_mode = full && (old_sample <= sample);
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] lv, rv;
      swm_nbr_type                   lf, rf;
      logic                          occ;

      assign occ = (fill_ff > CNT_W'(i));
      if (i == 0) begin : g_first
         assign lv = '0;
         assign lf = '{le: 1'b1, eqo: 1'b0, before_rm: 1'b1};
      end else begin : g_mid
         assign lv = cell_value[i-1];
         assign lf = cell_flags[i-1];
      end
      if (i == WINDOW_MAX - 1) begin : g_last
         assign rv = '0;
         assign rf = '{le: 1'b0, eqo: 1'b0, before_rm: 1'b0};
      end else begin : g_inner
         assign rv = cell_value[i+1];
         assign rf = cell_flags[i+1];
      end

      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .sample      (sample),
         .old_sample  (old_sample),
         .occ         (occ),
         .left_value  (lv),
         .left_flags  (lf),
         .right_value (rv),
         .right_flags (rf),
         .value       (cell_value[i]),
         .flags       (cell_flags[i])
      );
   end

   // Middle taps and their sum
   always_comb begin
      tap_a = '0;
      tap_b = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         tap_a = tap_a | (mask_a_ff[i] ? cell_value[i] : '0);
         tap_b = tap_b | (mask_b_ff[i] ? cell_value[i] : '0);
      end
      median = (SAMPLE_BITS + 1)'(tap_a) + (SAMPLE_BITS + 1)'(tap_b);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= median;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule

/* hw/rtl/swm_checker.sv */
// Port-level checks of the sliding window median filter, bound to its top.
`timescale 1ns / 1ps

module swm_checker #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
   localparam int RSP_W      = ((SAMPLE_BITS + 8) / 8) * 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_W-1:0]          rsp_tdata
);
   import swm_pkg::*;

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // A fresh response follows a taken request through the pending flag and output register
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without a request");

   // Requests are held off only behind a stalled response
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request held off without output stall");

   // Padding above the median is zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >> (SAMPLE_BITS + 1)) == '0))
      else $error("response padding not zero");

endmodule

bind sliding_window_median_top swm_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (.*);

/* test/sliding_window_median_top_tb.sv */
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 1ps

module sliding_window_median_top_tb;

   localparam int WIN_MAX       = swm_pkg::WINDOW_MAX_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 160;

   // Directed rows: either a sample request or a window length write
   typedef enum bit {ROW_SAMPLE, ROW_WINDOW} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  value;   // sample, or window length in the low bits
      bit           typed;   // want holds the known doubled median
      logic [16:0]  want;
   } dir_row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata  = '0;   // [15:0] sample
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [23:0]               rsp_tdata;         // [16:0] median_doubled
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [swm_pkg::CFG_W-1:0] csr_data   = '0;   // window_length

   // Predictor state: window length register and the samples in the window
   logic [swm_pkg::CFG_W-1:0] window_reg = 6'(swm_pkg::CFG_RESET);
   logic signed [15:0]        window_samples[$];
   logic [16:0]               median_pending[$];

   int   mismatch_count = 0;
   int   results_seen   = 0;
   int   samples_sent   = 0;
   int   lengths_used   = 0;
   int   burst_left     = 0;
   bit   req_held       = 1'b0;
   int   stall_pct      = 0;
   int   rx_cycle       = 0;

   dir_row_type directed_rows [22];

   sliding_window_median_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 50 MHz clock
   initial begin
      forever #10 clock = ~clock;
   end

   // Zero reads as one, anything above the store size saturates
   function automatic int window_span(input logic [swm_pkg::CFG_W-1:0] len);
      if (len == 0) return 1;
      if (len > WIN_MAX) return WIN_MAX;
      return int'(len);
   endfunction

   // Slide one sample into the window; returns 1 with twice the median once full
   function automatic bit slide_median(input logic signed [15:0] s,
                                       output logic [16:0] med2);
      int                 span;
      int                 a;
      int                 b;
      logic signed [15:0] ordered [WIN_MAX];
      logic signed [15:0] tmp;
      span = window_span(window_reg);
      med2 = '0;
      if (window_samples.size() >= span) void'(window_samples.pop_front());
      window_samples = {window_samples, s};
      if (window_samples.size() < span) return 1'b0;
      // insertion sort of a copy
      for (int i = 0; i < span; i++) begin
         ordered[i] = window_samples[i];
         for (int j = i; j > 0; j--) begin
            if (ordered[j-1] > ordered[j]) begin
               tmp          = ordered[j];
               ordered[j]   = ordered[j-1];
               ordered[j-1] = tmp;
            end
         end
      end
      if (span % 2 == 1) begin
         a = ordered[span/2];
         b = a;
      end else begin
         a = ordered[span/2 - 1];
         b = ordered[span/2];
      end
      med2 = 17'(a + b);
      return 1'b1;
   endfunction

   // Mix of full-range, clustered, extreme and duplicate-heavy samples
   function automatic logic [15:0] pick_sample();
      int style;
      style = $urandom_range(0, 9);
      case (style)
         0, 1, 2, 3: begin
            return 16'($urandom);
         end
         4, 5: begin
            return 16'($urandom_range(0, 6) - 3);
         end
         6: begin
            case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         default: begin
            return 16'(1000 + $urandom_range(0, 40));
         end
      endcase
   endfunction

   // Lower the request valid at most once per step
   task automatic hold_sender();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   // One sample request, with bursts and random gaps between them
   task automatic send_sample(input logic [15:0] s, input bit typed,
                              input logic [16:0] want);
      logic [16:0] predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_held = 1'b1;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      if (slide_median(s, predicted)) begin
         if (typed) median_pending = {median_pending, want};
         else median_pending = {median_pending, predicted};
      end
      if (burst_left <= 0) burst_left = $urandom_range(1, 40);
      burst_left--;
      if (burst_left == 0 && $urandom_range(0, 3) != 0) begin
         hold_sender();
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Wait until every expected median is back, then let the pipe settle
   task automatic drain_results();
      hold_sender();
      while (median_pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Window length write, only once the block is idle
   task automatic write_window(input logic [swm_pkg::CFG_W-1:0] len);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_reg = len;
      window_samples.delete();
      lengths_used++;
   endtask

   // Response checker and receiver stall pattern
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (median_pending.size() == 0) begin
            $error("median_doubled: response with none expected, actual %0d",
                   $signed(rsp_tdata[16:0]));
            mismatch_count++;
         end else begin
            if (rsp_tdata[16:0] !== median_pending[0]) begin
               $error("median_doubled mismatch: expected %0d, actual %0d",
                      $signed(median_pending[0]), $signed(rsp_tdata[16:0]));
               mismatch_count++;
            end
            void'(median_pending.pop_front());
         end
      end
      rx_cycle++;
      if (rx_cycle % 200 == 0) begin
         case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 25;
            3: stall_pct = 60;
            default: stall_pct = 90;
         endcase
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Stimulus
   initial begin
      logic [swm_pkg::CFG_W-1:0] phase_len [12];

      directed_rows = '{
         // reset window of three at both extremes
         '{ROW_SAMPLE, 16'h7FFF, 1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h7FFF, 1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h7FFF, 1'b1, 17'h0FFFE},
         '{ROW_SAMPLE, 16'h8000, 1'b1, 17'h0FFFE},
         '{ROW_SAMPLE, 16'h8000, 1'b1, 17'h10000},
         '{ROW_SAMPLE, 16'h8000, 1'b1, 17'h10000},
         // even window: sum of both middles
         '{ROW_WINDOW, 16'd2,    1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h7FFF, 1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h8000, 1'b1, 17'h1FFFF},
         '{ROW_SAMPLE, 16'h7FFF, 1'b1, 17'h1FFFF},
         '{ROW_SAMPLE, 16'h7FFF, 1'b1, 17'h0FFFE},
         // zero length acts as one
         '{ROW_WINDOW, 16'd0,    1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h1234, 1'b1, 17'h02468},
         '{ROW_SAMPLE, 16'hFFFF, 1'b1, 17'h1FFFE},
         '{ROW_WINDOW, 16'd1,    1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h0000, 1'b1, 17'h00000},
         // repeated values leaving the window
         '{ROW_WINDOW, 16'd4,    1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h0001, 1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h0001, 1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h0002, 1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'h0001, 1'b0, 17'h00000},
         '{ROW_SAMPLE, 16'hFFFD, 1'b0, 17'h00000}
      };

      // wide, saturated, odd, even and tiny windows, plus two random ones
      phase_len = '{6'd63, 6'd32, 6'd31, 6'd33, 6'd7, 6'd8,
                    6'd0, 6'd1, 6'd2, 6'd16, 6'($urandom_range(0, 63)),
                    6'($urandom_range(0, 63))};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WINDOW)
            write_window(directed_rows[r].value[swm_pkg::CFG_W-1:0]);
         else
            send_sample(directed_rows[r].value, directed_rows[r].typed,
                        directed_rows[r].want);
      end

      foreach (phase_len[p]) begin
         write_window(phase_len[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off once mid-window until everything is back
            if (p == 4 && n == PHASE_ITEMS / 2) drain_results();
            send_sample(pick_sample(), 1'b0, 17'h0);
         end
      end

      drain_results();
      $display("Sent %0d samples over %0d window lengths, %0d medians checked.",
               samples_sent, lengths_used + 1, results_seen);
      $display("Covered fill, saturation, zero length, even/odd and repeat cases.");
      if (mismatch_count == 0) begin
         $display("sliding_window_median_top test passed");
      end else begin
         $display("sliding_window_median_top test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(4_000_000);
      $display("sliding_window_median_top test failed");
      $finish;
   end

endmodule
